>>> design/ictf_pkg.sv
// -----------------------------------------------------------------------------
// ictf_pkg
// Shared types, constants and the arctangent table of the tilt filter.
// -----------------------------------------------------------------------------
`default_nettype none

package ictf_pkg;

   // angle format and CORDIC table format
   localparam int ANGLE_FRAC_BITS  = 16;
   localparam int ANGLE_W          = 26;
   localparam int TAB_FRAC         = 24;
   localparam int TAB_LEN          = 24;
   localparam int TAB_IDX_W        = 5;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int SQRT_STEPS       = 32;
   localparam int ROUND_SHIFT      = TAB_FRAC - ANGLE_FRAC_BITS;

   // gyro increment divider
   localparam int DIV_NUM_W = 65;
   localparam int DIV_QUO_W = 57;
   localparam int DEN_W     = 26;
   localparam int DIV_CNT_W = 7;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GYRO_BIAS = 2'd0,
      CSR_COUNTS    = 2'd1,
      CSR_WEIGHT    = 2'd2
   } csr_index_type;

   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT =
      ANGLE_W'(360 * (1 << ANGLE_FRAC_BITS));
   localparam logic signed [ANGLE_W-1:0] ANGLE_90 =
      ANGLE_W'(90 * (1 << ANGLE_FRAC_BITS));
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   // one classified sample handed from front to back
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic [31:0]        tilt_sq;   // ay^2 + az^2
      logic [31:0]        dt;
      logic signed [16:0] rate;      // gyro minus bias
   } work_item_type;

   // atan(2^-i) in Q24 degrees
   function automatic logic signed [31:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:    val = 32'sd754974720;
         5'd1:    val = 32'sd445687602;
         5'd2:    val = 32'sd235489088;
         5'd3:    val = 32'sd119537938;
         5'd4:    val = 32'sd60000934;
         5'd5:    val = 32'sd30029717;
         5'd6:    val = 32'sd15018523;
         5'd7:    val = 32'sd7509720;
         5'd8:    val = 32'sd3754917;
         5'd9:    val = 32'sd1877466;
         5'd10:   val = 32'sd938734;
         5'd11:   val = 32'sd469367;
         5'd12:   val = 32'sd234684;
         5'd13:   val = 32'sd117342;
         5'd14:   val = 32'sd58671;
         5'd15:   val = 32'sd29335;
         5'd16:   val = 32'sd14668;
         5'd17:   val = 32'sd7334;
         5'd18:   val = 32'sd3667;
         5'd19:   val = 32'sd1833;
         5'd20:   val = 32'sd917;
         5'd21:   val = 32'sd458;
         5'd22:   val = 32'sd229;
         5'd23:   val = 32'sd115;
         default: val = 32'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> design/ictf_ifs.sv
// -----------------------------------------------------------------------------
// ictf channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// -----------------------------------------------------------------------------
`default_nettype none

interface ictf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] gyro_y;
   logic [31:0]        time_ms;
   modport source (output valid, accel_x, accel_y, accel_z, gyro_y, time_ms,
                   input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_y, time_ms,
                 output ready);
endinterface

interface ictf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ictf_pkg::ANGLE_W-1:0] fused_angle;
   modport source (output valid, fused_angle, input ready);
   modport sink (input valid, fused_angle, output ready);
endinterface

interface ictf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ictf_pkg::CSR_IDX_W-1:0]    index;
   logic [ictf_pkg::CSR_DATA_W-1:0]   wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

>>> design/ictf_front.sv
// -----------------------------------------------------------------------------
// ictf_front
// Takes samples, forms elapsed time, tilt square sum and corrected gyro rate.
// -----------------------------------------------------------------------------
`default_nettype none

module ictf_front (
   input  logic                          clock,
   input  logic                          reset,
   ictf_req_if.sink                      req,
   input  logic signed [15:0]            gyro_bias,
   output logic                          work_valid,
   input  logic                          work_ready,
   output ictf_pkg::work_item_type       work_item
);
   import ictf_pkg::*;

   logic               stage_valid_ff, stage_valid_in;
   logic signed [15:0] ax_ff, ay_ff, az_ff, gy_ff;
   logic [31:0]        time_ff;
   logic [31:0]        last_time_ff;
   logic               accept, push;
   logic signed [31:0] ay_sq, az_sq;

   // hold one sample until the queue takes it
   assign push           = stage_valid_ff && work_ready;
   assign req.ready      = !stage_valid_ff || work_ready;
   assign accept         = req.valid && req.ready;
   assign stage_valid_in = accept || (stage_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         last_time_ff   <= 32'd0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (push) begin
            last_time_ff <= time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff   <= req.accel_x;
         ay_ff   <= req.accel_y;
         az_ff   <= req.accel_z;
         gy_ff   <= req.gyro_y;
         time_ff <= req.time_ms;
      end
   end

   // classify the staged sample
   assign ay_sq = ay_ff * ay_ff;
   assign az_sq = az_ff * az_ff;

   assign work_valid         = stage_valid_ff;
   assign work_item.accel_x  = ax_ff;
   assign work_item.tilt_sq  = {1'b0, ay_sq[30:0]} + {1'b0, az_sq[30:0]};
   assign work_item.dt       = time_ff - last_time_ff;
   assign work_item.rate     = {gy_ff[15], gy_ff} - {gyro_bias[15], gyro_bias};

endmodule

`default_nettype wire

>>> design/ictf_queue.sv
// -----------------------------------------------------------------------------
// ictf_queue
// Small register FIFO that decouples the front from the back.
// -----------------------------------------------------------------------------
`default_nettype none

module ictf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  ictf_pkg::work_item_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output ictf_pkg::work_item_type pop_data
);
   import ictf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> design/ictf_back.sv
// -----------------------------------------------------------------------------
// ictf_back
// Square root, CORDIC, gyro divider and blend; drives the result register.
// -----------------------------------------------------------------------------
`default_nettype none

module ictf_back #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    work_valid,
   output logic                    work_ready,
   input  ictf_pkg::work_item_type work_item,
   input  logic [15:0]             counts_per_dps,
   input  logic [16:0]             blend_weight,
   ictf_rsp_if.source              rsp
);
   import ictf_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SQRT   = 10'b0000000010,
      ST_CORDIC = 10'b0000000100,
      ST_WAIT   = 10'b0000001000,
      ST_TMP    = 10'b0000010000,
      ST_DIFF   = 10'b0000100000,
      ST_MLO    = 10'b0001000000,
      ST_MHI    = 10'b0010000000,
      ST_SUM    = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } back_state_type;

   back_state_type              state_ff;
   logic [TAB_IDX_W-1:0]        step_ff;

   // square root
   logic [31:0]                 sq_src_ff;
   logic [33:0]                 rem_ff;
   logic [31:0]                 root_ff;
   logic [35:0]                 sq_rem_sh, sq_trial, sq_diff;
   logic                        sq_ge;
   logic [31:0]                 root_next;

   // CORDIC
   logic signed [35:0]          x_ff, y_ff, cx_dx, cx_dy, y_init;
   logic signed [31:0]          z_ff, cx_tab;
   logic signed [15:0]          ax_ff;
   logic                        level_ff;
   logic signed [32:0]          z_round;

   // divider
   logic                        div_busy_ff;
   logic [DIV_CNT_W-1:0]        div_cnt_ff;
   logic [DIV_NUM_W-1:0]        div_nq_ff;
   logic [DEN_W-1:0]            div_rem_ff, den_ff, den_load;
   logic [DEN_W:0]              div_rem_sh;
   logic                        div_ge;
   logic                        neg_ff;
   logic [16:0]                 rate_mag;
   logic signed [17:0]          rate_neg;
   logic [48:0]                 num_load;
   logic [15:0]                 counts_eff;

   // blend
   logic signed [ANGLE_W-1:0]   est_ff, acc_ff, acc_new, sat_val;
   logic signed [58:0]          tmp_ff, sinc, diff_full;
   logic signed [42:0]          diffc_ff;
   logic [16:0]                 w_eff;
   logic [37:0]                 plo_ff;
   logic signed [39:0]          phi_ff;
   logic signed [60:0]          prod;
   logic signed [60:0]          scaled;
   logic signed [45:0]          fused_ff;
   logic                        out_load;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0]   rsp_angle_ff;

   localparam logic signed [58:0] DIFF_CAP = 59'sd1 <<< 41;

   assign work_ready = state_ff == ST_IDLE;

   // load values
   assign rate_neg   = -{work_item.rate[16], work_item.rate};
   assign rate_mag   = work_item.rate[16] ? rate_neg[16:0] : work_item.rate;
   assign num_load   = rate_mag * work_item.dt;
   assign counts_eff = (counts_per_dps == 16'd0) ? 16'd1 : counts_per_dps;
   assign den_load   = counts_eff * 10'd1000;

   // square root step: two radicand bits a cycle
   assign sq_rem_sh = {rem_ff, sq_src_ff[31:30]};
   assign sq_trial  = {2'b00, root_ff, 2'b01};
   assign sq_ge     = sq_rem_sh >= sq_trial;
   assign sq_diff   = sq_rem_sh - sq_trial;
   assign root_next = {root_ff[30:0], sq_ge};
   assign y_init    = -($signed({{20{ax_ff[15]}}, ax_ff}) <<< ANGLE_FRAC_BITS);

   // CORDIC step
   assign cx_dx  = y_ff >>> step_ff;
   assign cx_dy  = x_ff >>> step_ff;
   assign cx_tab = atan_q24(step_ff);

   // round the angle half up, keeping its sign
   assign z_round = ($signed({z_ff[31], z_ff}) + (33'sd1 <<< (ROUND_SHIFT - 1)))
                    >>> ROUND_SHIFT;
   always_comb begin
      if (!level_ff) begin
         acc_new = z_round[ANGLE_W-1:0];
      end else if (ax_ff == 16'sd0) begin
         acc_new = '0;
      end else if (ax_ff[15]) begin
         acc_new = ANGLE_90;
      end else begin
         acc_new = -ANGLE_90;
      end
   end

   // divider step: one quotient bit a cycle
   assign div_rem_sh = {div_rem_ff, div_nq_ff[DIV_NUM_W-1]};
   assign div_ge     = div_rem_sh >= {1'b0, den_ff};

   // blend arithmetic
   assign sinc      = neg_ff ? -$signed({2'b00, div_nq_ff[DIV_QUO_W-1:0]})
                             :  $signed({2'b00, div_nq_ff[DIV_QUO_W-1:0]});
   assign diff_full = tmp_ff - 59'(acc_ff);
   assign w_eff     = (blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight;
   assign prod      = (61'(phi_ff) <<< 21) + $signed({23'd0, plo_ff});
   assign scaled    = prod >>> 16;

   always_comb begin
      if (fused_ff > 46'(ANGLE_LIMIT)) begin
         sat_val = ANGLE_LIMIT;
      end else if (fused_ff < -46'(ANGLE_LIMIT)) begin
         sat_val = -ANGLE_LIMIT;
      end else begin
         sat_val = fused_ff[ANGLE_W-1:0];
      end
   end

   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         est_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (div_busy_ff && div_cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            div_busy_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (work_valid) begin
                  state_ff    <= ST_SQRT;
                  div_busy_ff <= 1'b1;
               end
            end
            ST_SQRT: begin
               if (step_ff == TAB_IDX_W'(SQRT_STEPS - 1)) begin
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (step_ff == TAB_IDX_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (!div_busy_ff) begin
                  state_ff <= ST_TMP;
               end
            end
            ST_TMP:  state_ff <= ST_DIFF;
            ST_DIFF: state_ff <= ST_MLO;
            ST_MLO:  state_ff <= ST_MHI;
            ST_MHI:  state_ff <= ST_SUM;
            ST_SUM:  state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_load) begin
                  est_ff   <= sat_val;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_busy_ff) begin
         div_rem_ff <= div_ge ? DEN_W'(div_rem_sh - {1'b0, den_ff}) : div_rem_sh[DEN_W-1:0];
         div_nq_ff  <= {div_nq_ff[DIV_NUM_W-2:0], div_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            sq_src_ff  <= work_item.tilt_sq;
            rem_ff     <= '0;
            root_ff    <= '0;
            step_ff    <= '0;
            ax_ff      <= work_item.accel_x;
            level_ff   <= work_item.tilt_sq == 32'd0;
            div_nq_ff  <= {num_load, 16'd0};
            div_rem_ff <= '0;
            div_cnt_ff <= '0;
            den_ff     <= den_load;
            neg_ff     <= work_item.rate[16];
         end
         ST_SQRT: begin
            rem_ff    <= sq_ge ? sq_diff[33:0] : sq_rem_sh[33:0];
            root_ff   <= root_next;
            sq_src_ff <= {sq_src_ff[29:0], 2'b00};
            if (step_ff == TAB_IDX_W'(SQRT_STEPS - 1)) begin
               x_ff    <= $signed({4'd0, root_next});
               y_ff    <= y_init;
               z_ff    <= '0;
               step_ff <= '0;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
         ST_CORDIC: begin
            if (!y_ff[35]) begin
               x_ff <= x_ff + cx_dx;
               y_ff <= y_ff - cx_dy;
               z_ff <= z_ff + cx_tab;
            end else begin
               x_ff <= x_ff - cx_dx;
               y_ff <= y_ff + cx_dy;
               z_ff <= z_ff - cx_tab;
            end
            step_ff <= step_ff + 1'b1;
         end
         ST_WAIT: acc_ff <= acc_new;
         ST_TMP:  tmp_ff <= 59'(est_ff) + sinc;
         ST_DIFF: begin
            // large gaps saturate either way, so cap them
            if (diff_full > DIFF_CAP) begin
               diffc_ff <= DIFF_CAP[42:0];
            end else if (diff_full < -DIFF_CAP) begin
               diffc_ff <= 43'(-DIFF_CAP);
            end else begin
               diffc_ff <= diff_full[42:0];
            end
         end
         ST_MLO:  plo_ff   <= w_eff * diffc_ff[20:0];
         ST_MHI:  phi_ff   <= $signed({1'b0, w_eff}) * $signed(diffc_ff[42:21]);
         ST_SUM:  fused_ff <= 46'(acc_ff) + scaled[45:0];
         ST_OUT: begin
            if (out_load) begin
               rsp_angle_ff <= sat_val;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.fused_angle = rsp_angle_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_busy_ff)
      else $error("divider busy while back end idle");

   a_wait_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && !div_busy_ff) |=> (state_ff == ST_TMP))
      else $error("blend did not start after divider finished");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_angle_ff <= ANGLE_LIMIT && rsp_angle_ff >= -ANGLE_LIMIT))
      else $error("result outside saturation limits");

   a_est_match: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && rsp_angle_ff == est_ff))
      else $error("estimate differs from delivered result");

endmodule

`default_nettype wire

>>> design/imu_tilt_complementary_filter_top.sv
// -----------------------------------------------------------------------------
// imu_tilt_complementary_filter_top
// Complementary tilt filter: accelerometer CORDIC angle blended with gyro rate.
// -----------------------------------------------------------------------------
// Each sample on req_bus yields one fused angle on rsp_bus, signed Q16 degrees
// saturated at +-360. In the back end a sample is loaded, the bit-serial
// divider forms the gyro increment (the square root and then the CORDIC run
// beside it), and once the divider is done the angle is captured, blended
// and output. The front registers the next sample and a two-entry queue
// holds more while the back end works; the back end takes no new sample
// until its result is loaded into the output register. Configuration writes
// on csr_bus are always accepted and must be made while the filter is idle.
// -----------------------------------------------------------------------------
`default_nettype none

module imu_tilt_complementary_filter_top #(
   parameter int CORDIC_STEPS = ictf_pkg::CORDIC_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   ictf_req_if.sink      req_bus,
   ictf_rsp_if.source    rsp_bus,
   ictf_csr_if.sink      csr_bus
);
   import ictf_pkg::*;

   logic signed [15:0] bias_ff;
   logic [15:0]        counts_ff;
   logic [16:0]        weight_ff;
   logic               csr_write;

   logic               fr_valid, fr_ready, bk_valid, bk_ready;
   work_item_type      fr_item, bk_item;

   // configuration registers
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff   <= 16'sd0;
         counts_ff <= 16'd131;
         weight_ff <= 17'd63015;
      end else if (csr_write) begin
         case (csr_bus.index)
            CSR_GYRO_BIAS: bias_ff   <= csr_bus.wdata[15:0];
            CSR_COUNTS:    counts_ff <= csr_bus.wdata[15:0];
            CSR_WEIGHT:    weight_ff <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   ictf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .gyro_bias  (bias_ff),
      .work_valid (fr_valid),
      .work_ready (fr_ready),
      .work_item  (fr_item)
   );

   ictf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  (fr_item),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_item)
   );

   ictf_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .work_valid     (bk_valid),
      .work_ready     (bk_ready),
      .work_item      (bk_item),
      .counts_per_dps (counts_ff),
      .blend_weight   (weight_ff),
      .rsp            (rsp_bus)
   );

endmodule

`default_nettype wire

>>> tb/imu_tilt_complementary_filter_top_tb.sv
// -----------------------------------------------------------------------------
// imu_tilt_complementary_filter_top_tb
// Self-checking bench for the complementary tilt filter. Samples are driven
// on the request channel with random gaps. Each accepted sample is run through
// a bit-exact fixed-point model of the filter, and every fused angle that
// comes back is compared in order. Several register settings are covered,
// the extremes among them.
// -----------------------------------------------------------------------------
`default_nettype none

module imu_tilt_complementary_filter_top_tb;
   import ictf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_y;
      logic [31:0]        time_ms;
   } tilt_sample_type;

   // ---------------------------------------------------------------------------
   // Filter model and queue of expected fused angles
   // ---------------------------------------------------------------------------
   class tilt_scoreboard;
      longint                  bias;
      longint unsigned         counts;
      longint unsigned         weight;
      longint                  estimate;
      logic [31:0]             prev_time;
      logic [ANGLE_W-1:0]      expected_angles[$];
      int                      mismatches;
      int                      errors;

      function new();
         bias = 0; counts = 131; weight = 63015;
         estimate = 0; prev_time = 0;
         mismatches = 0; errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GYRO_BIAS: bias   = longint'($signed(data[15:0]));
            CSR_COUNTS:    counts = longint'(data[15:0]);
            CSR_WEIGHT:    weight = longint'(data[16:0]);
            default: ;
         endcase
      endfunction

      function longint unsigned root64(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function longint tilt_from_accel(longint ax, longint ay, longint az);
         longint x, y, z, dx, dy;
         longint unsigned sq;
         z = 0;
         // level sensor: straight up, down, or no reading at all
         if (ay == 0 && az == 0) begin
            if (ax == 0) return 0;
            return (ax < 0) ? 90 * 65536 : -90 * 65536;
         end
         sq = longint'(ay * ay + az * az);
         x = longint'(root64(sq << 32));
         y = -ax * 65536;
         for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += longint'(atan_q24_val(i));
            end else begin
               x -= dx; y += dy; z -= longint'(atan_q24_val(i));
            end
         end
         return (z + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      endfunction

      function longint atan_q24_val(int i);
         longint arc[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                             30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                             469367, 234684, 117342, 58671, 29335, 14668, 7334,
                             3667, 1833, 917, 458, 229, 115};
         return arc[i];
      endfunction

      function longint gyro_step(longint gy, logic [31:0] dt);
         longint d;
         longint unsigned mag, den, num, q, r, inc;
         d = gy - bias;
         mag = (d < 0) ? -d : d;
         den = ((counts == 0) ? 1 : counts) * 1000;
         num = mag * longint'(dt);
         q = num / den;
         r = num % den;
         inc = (q << ANGLE_FRAC_BITS) + ((r << ANGLE_FRAC_BITS) / den);
         return (d < 0) ? -longint'(inc) : longint'(inc);
      endfunction

      // predict the fused angle of one accepted sample
      function void note_sample(tilt_sample_type s);
         longint acc, mixed, w, diff, hi, fused, lim;
         longint unsigned lo;
         logic [31:0] dt;
         lim = 360 * 65536;
         dt = s.time_ms - prev_time;
         acc = tilt_from_accel(s.accel_x, s.accel_y, s.accel_z);
         mixed = estimate + gyro_step(s.gyro_y, dt);
         w = (weight > 65536) ? 65536 : weight;
         diff = mixed - acc;
         hi = diff >>> 16;
         lo = diff & 64'hFFFF;
         fused = acc + w * hi + longint'((w * lo) >> 16);
         if (fused > lim) fused = lim;
         if (fused < -lim) fused = -lim;
         estimate = fused;
         prev_time = s.time_ms;
         expected_angles.push_back(fused[ANGLE_W-1:0]);
      endfunction

      function void check_angle(logic [ANGLE_W-1:0] actual);
         logic [ANGLE_W-1:0] want;
         if (expected_angles.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected fused angle %0d", $signed(actual));
            return;
         end
         want = expected_angles.pop_front();
         if (want !== actual) begin
            errors++;
            if (mismatches++ < 10)
               $display("fused_angle mismatch: expected %0d actual %0d",
                        $signed(want), $signed(actual));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   hold_req = 1'b0;
   bit   no_idle = 1'b0;
   logic [31:0] next_time = 0;

   ictf_req_if req_bus ();
   ictf_rsp_if rsp_bus ();
   ictf_csr_if csr_bus ();

   tilt_scoreboard sb = new();

   imu_tilt_complementary_filter_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.accel_x = '0; req_bus.accel_y = '0; req_bus.accel_z = '0;
      req_bus.gyro_y = '0;  req_bus.time_ms = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0; csr_bus.index = '0; csr_bus.wdata = '0;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int p;
      p = $urandom_range(99);
      if (no_idle || p < 55) return 0;
      if (p < 85) return $urandom_range(3, 1);
      if (p < 97) return $urandom_range(20, 4);
      return $urandom_range(150, 50);
   endfunction

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("imu_tilt_complementary_filter_top_tb: errors");
         $finish;
      end
   end

   // note accepted items and check results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.write_reg(csr_bus.index, csr_bus.wdata);
         if (req_bus.valid && req_bus.ready) begin
            tilt_sample_type s;
            s.accel_x = req_bus.accel_x; s.accel_y = req_bus.accel_y;
            s.accel_z = req_bus.accel_z; s.gyro_y = req_bus.gyro_y;
            s.time_ms = req_bus.time_ms;
            sb.note_sample(s);
         end
         if (rsp_bus.valid && rsp_bus.ready) sb.check_angle(rsp_bus.fused_angle);
      end
   end

   // result receiver: random stalls plus one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         n = idle_len();
         if (n == 0) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   // offer one item, idle afterwards only when a gap is drawn
   task automatic send_sample(tilt_sample_type s);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.accel_x <= s.accel_x;
      req_bus.accel_y <= s.accel_y;
      req_bus.accel_z <= s.accel_z;
      req_bus.gyro_y  <= s.gyro_y;
      req_bus.time_ms <= s.time_ms;
      do @(posedge clock); while (!req_bus.ready);
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(int ax, int ay, int az, int gy, logic [31:0] t);
      tilt_sample_type s;
      s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
      s.gyro_y = 16'(gy); s.time_ms = t;
      send_sample(s);
   endtask

   // plausible motion, level sensors and raw noise, mostly advancing time
   task automatic send_random(int count);
      tilt_sample_type s;
      int p;
      for (int k = 0; k < count; k++) begin
         p = $urandom_range(99);
         s.accel_x = 16'($urandom); s.accel_y = 16'($urandom);
         s.accel_z = 16'($urandom); s.gyro_y = 16'($urandom);
         if (p < 8) begin
            s.accel_y = 0; s.accel_z = 0;
         end else if (p < 40) begin
            s.accel_x = 16'(int'($urandom_range(4000)) - 2000);
            s.gyro_y  = 16'(int'($urandom_range(2000)) - 1000);
         end
         if (p >= 90) next_time = $urandom;
         else next_time = next_time + $urandom_range(20, 1);
         s.time_ms = next_time;
         send_sample(s);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_angles.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes, level sensor, time wrap
      send_fields(0, 0, 0, 0, 0);
      send_fields(-32768, 0, 0, 0, 1);
      send_fields(32767, 0, 0, 0, 2);
      send_fields(0, -32768, -32768, 32767, 10);
      send_fields(-32768, 32767, 32767, -32768, 20);
      send_fields(32767, -32768, 0, 100, 30);
      send_fields(100, 0, -32768, -100, 40);
      send_fields(-1, 1, 0, 0, 32'hFFFF_FFFF);
      send_fields(1, 0, 1, 5, 3);
      send_fields(0, 16000, 0, -32768, 32'h8000_0000);
      drain();

      // zero counts, large weight, lowest bias: saturation
      write_csr(CSR_GYRO_BIAS, 17'h08000);
      write_csr(CSR_COUNTS, 17'd0);
      write_csr(CSR_WEIGHT, 17'h1FFFF);
      send_fields(0, 0, 16384, 32767, 32'h7000_0000);
      send_fields(0, 0, 16384, -32768, 32'h7000_1000);
      send_random(70);
      drain();

      // pure accelerometer path
      write_csr(CSR_GYRO_BIAS, 17'h07FFF);
      write_csr(CSR_COUNTS, 17'd65535);
      write_csr(CSR_WEIGHT, 17'd0);
      no_idle = 1'b1;
      send_random(40);
      no_idle = 1'b0;
      send_random(40);
      drain();

      // pure gyro path, one count per dps; ignored index in between
      write_csr(CSR_GYRO_BIAS, 17'd0);
      write_csr(CSR_COUNTS, 17'd1);
      write_csr(CSR_WEIGHT, 17'd65536);
      csr_bus.valid <= 1'b1; csr_bus.index <= 2'd3; csr_bus.wdata <= 17'h1ABCD;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      send_random(80);
      drain();

      // nominal settings; receiver holds off while samples keep coming
      write_csr(CSR_GYRO_BIAS, 17'($urandom));
      write_csr(CSR_COUNTS, 17'd131);
      write_csr(CSR_WEIGHT, 17'd63015);
      hold_req = 1'b1;
      send_random(100);
      drain();

      // random settings
      write_csr(CSR_GYRO_BIAS, 17'($urandom));
      write_csr(CSR_COUNTS, 17'($urandom_range(65535)));
      write_csr(CSR_WEIGHT, 17'($urandom_range(65536)));
      send_random(110);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_angles.size() == 0)
         $display("imu_tilt_complementary_filter_top_tb: clean");
      else
         $display("imu_tilt_complementary_filter_top_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
